/* sv/cppd_pkg.sv */
// shared types, constants and saturation helpers for the projection block
package cppd_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC   = 24;
	localparam int ACC_W  = 36;
	localparam int OPND_W = 34;
	localparam int PROD_W = 66;

	localparam logic [2:0] REG_FOCAL     = 3'd0;
	localparam logic [2:0] REG_PRINCIPAL = 3'd1;
	localparam logic [2:0] REG_RAD_NUM   = 3'd2;
	localparam logic [2:0] REG_RAD_MIX   = 3'd3;
	localparam logic [2:0] REG_RAD_DEN   = 3'd4;
	localparam logic [2:0] REG_TANG      = 3'd5;
	localparam logic [2:0] REG_IMAGE     = 3'd6;
	localparam logic [2:0] REG_MIN_DIST  = 3'd7;

	localparam logic [31:0] MIN_DIST_RST = 32'h000A_0000;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [OPND_W-1:0] opnd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XGO,
		ST_XWAIT,
		ST_YGO,
		ST_YWAIT,
		ST_POLY,
		ST_CGO,
		ST_CWAIT,
		ST_TAN,
		ST_DIST,
		ST_OUT
	} state_t;

	function automatic word_t sat_sign(input logic neg);
		sat_sign = neg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
	endfunction

	function automatic word_t sat_word(input acc_t v);
		acc_t hi;
		acc_t lo;
		hi = acc_t'({1'b0, {(WORD_W-1){1'b1}}});
		lo = -hi - acc_t'(1);
		if (v > hi)
			sat_word = sat_sign(1'b0);
		else if (v < lo)
			sat_word = sat_sign(1'b1);
		else
			sat_word = v[WORD_W-1:0];
	endfunction

	function automatic acc_t ext_acc(input word_t v);
		ext_acc = acc_t'(v);
	endfunction

	function automatic opnd_t ext_opnd(input word_t v);
		ext_opnd = opnd_t'(v);
	endfunction

endpackage

/* sv/cppd_mul.sv */
// shared signed multiplier with q24 truncation and saturation
module cppd_mul (
	input  logic                        clk,
	input  cppd_pkg::opnd_t             a,
	input  cppd_pkg::opnd_t             b,
	output logic [63:0]                 prod,
	output cppd_pkg::word_t             mq
);
	import cppd_pkg::*;

	logic [OPND_W-1:0] a_abs;
	logic [OPND_W-1:0] b_abs;
	logic [PROD_W-1:0] prod_s1;
	logic              neg_s1;
	logic [WORD_W-1:0] mag;

	assign a_abs = a[OPND_W-1] ? OPND_W'(-a) : OPND_W'(a);
	assign b_abs = b[OPND_W-1] ? OPND_W'(-b) : OPND_W'(b);

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a_abs[OPND_W-2:0]) * PROD_W'(b_abs[OPND_W-2:0]);
		neg_s1  <= a[OPND_W-1] ^ b[OPND_W-1];
	end

	assign prod = prod_s1[63:0];
	assign mag  = {1'b0, prod_s1[FRAC+WORD_W-2:FRAC]};

	always_comb begin
		if (|prod_s1[PROD_W-1:FRAC+WORD_W-1])
			mq = sat_sign(neg_s1);
		else
			mq = neg_s1 ? word_t'(-mag) : word_t'(mag);
	end
endmodule

/* sv/cppd_div.sv */
// radix-4 restoring divider for q24 quotients, two bits a cycle
module cppd_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cppd_pkg::word_t num,
	input  cppd_pkg::word_t den,
	output logic            done,
	output cppd_pkg::word_t quo
);
	import cppd_pkg::*;

	logic [31:0] un;
	logic [31:0] ud;
	logic [31:0] ud_q;
	logic [31:0] rem_q;
	logic [31:0] dd_q;
	logic [31:0] quo_q;
	logic        neg_q;
	logic        busy_q;
	logic        fin_q;
	logic [3:0]  cnt_q;
	word_t       res_q;
	logic [32:0] r1;
	logic [32:0] r2;
	logic        b1;
	logic        b2;
	logic [31:0] r1n;
	logic [31:0] r2n;
	logic [31:0] nquo;
	logic        ovf;

	assign un  = num[31] ? 32'(-num) : 32'(num);
	assign ud  = den[31] ? 32'(-den) : 32'(den);
	assign ovf = {7'd0, un} >= {ud, 7'd0};

	always_comb begin
		r1  = {rem_q, dd_q[31]};
		b1  = r1 >= {1'b0, ud_q};
		r1n = b1 ? 32'(r1 - {1'b0, ud_q}) : r1[31:0];
		r2  = {r1n, dd_q[30]};
		b2  = r2 >= {1'b0, ud_q};
		r2n = b2 ? 32'(r2 - {1'b0, ud_q}) : r2[31:0];
		nquo = {quo_q[29:0], b1, b2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (den == '0 || ovf) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[31] ^ den[31];
			ud_q  <= ud;
			rem_q <= {8'd0, un[31:8]};
			dd_q  <= {un[7:0], 24'd0};
			quo_q <= '0;
			if (den == '0)
				res_q <= (num == '0) ? word_t'(0) : sat_sign(num[31]);
			else if (ovf)
				res_q <= sat_sign(num[31] ^ den[31]);
		end else if (busy_q) begin
			rem_q <= r2n;
			dd_q  <= {dd_q[29:0], 2'b00};
			quo_q <= nquo;
			if (cnt_q == 4'd15)
				res_q <= neg_q ? word_t'(-nquo) : word_t'(nquo);
		end
	end

	assign done = fin_q;
	assign quo  = res_q;
endmodule

/* sv/camera_point_projection_distortion.sv */
// top level: sequencer, register file and datapath around the shared units
// A corner in front of the camera goes through the x and y divisions, the radial
// polynomial, the radial division and the tangential terms, a fourth corner then
// through the six distance checks; one at or behind the camera plane skips to the
// checks (fourth corner) or the result. The quotients x, y and the radial factor
// each pass the shared divider, which retires two quotient bits a cycle, and the
// 19 products of the projection plus 13 of the distance checks go one a cycle
// through the single shared multiplier. A new request is taken only when idle;
// a finished result waits in the output register while the next one is worked.
module camera_point_projection_distortion (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [2:0]             cfg_index,
	input  logic [63:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [31:0]     cam_x,
	input  logic signed [31:0]     cam_y,
	input  logic signed [31:0]     cam_z,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [31:0]     pixel_u,
	output logic signed [31:0]     pixel_v,
	output logic                   inside_image,
	output logic                   behind_camera,
	output logic [1:0]             corner_number,
	output logic                   last_corner,
	output logic                   target_valid
);
	import cppd_pkg::*;

	logic [63:0] focal_q, principal_q, rad_num_q, rad_mix_q, rad_den_q, tang_q;
	logic [31:0] image_q, min_dist_q;

	state_t state_q, state_d;
	logic [3:0] step_q;

	word_t cx_q, cy_q, cz_q;
	word_t x_q, y_q, x2_q, y2_q, xy_q, r2_q, r4_q, r6_q, tx_q, ty_q;
	word_t n_q, d_q, c_q, xd_q, yd_q, u_q, v_q;
	acc_t  acc_q;
	logic  behind_q, far_q, gai_q;
	logic [1:0] count_q;
	word_t prior_u_q [3];
	word_t prior_v_q [3];
	logic [63:0] mm_q, a_q;

	opnd_t mul_a, mul_b;
	logic [63:0] prod;
	word_t mq;
	logic  div_start;
	word_t div_num, div_den, div_quo;
	logic  div_done;

	logic  accept, out_ok, last, in_image;
	word_t one;
	word_t r2s;
	logic [2:0] pidx;
	word_t pa_u, pa_v, pb_u, pb_v;
	logic signed [32:0] du, dv;
	logic [64:0] dsum;
	logic  far_now;

	assign one    = word_t'(1) <<< FRAC;
	assign accept = in_valid && !in_stall;
	assign out_ok = !out_valid || !out_stall;
	assign last   = count_q == 2'd3;
	assign r2s    = sat_word(ext_acc(x2_q) + ext_acc(y2_q));
	assign in_image = !behind_q && !u_q[31] && !v_q[31]
		&& (u_q < {image_q[31:16], 16'd0}) && (v_q < {image_q[15:0], 16'd0});
	assign pidx   = 3'((step_q - 4'd1) >> 1);
	assign du     = 33'(pa_u) - 33'(pb_u);
	assign dv     = 33'(pa_v) - 33'(pb_v);
	assign dsum   = {1'b0, a_q} + {1'b0, prod};
	assign far_now = dsum[64] || (dsum[63:0] >= mm_q);

	cppd_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod),
		.mq   (mq)
	);

	cppd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		pa_u = prior_u_q[0]; pa_v = prior_v_q[0];
		pb_u = prior_u_q[1]; pb_v = prior_v_q[1];
		case (pidx)
			3'd1: begin
				pa_u = prior_u_q[1]; pa_v = prior_v_q[1];
				pb_u = prior_u_q[2]; pb_v = prior_v_q[2];
			end
			3'd2: begin
				pa_u = prior_u_q[2]; pa_v = prior_v_q[2];
				pb_u = u_q; pb_v = v_q;
			end
			3'd3: begin
				pa_u = u_q; pa_v = v_q;
				pb_u = prior_u_q[0]; pb_v = prior_v_q[0];
			end
			3'd4: begin
				pa_u = prior_u_q[1]; pa_v = prior_v_q[1];
				pb_u = u_q; pb_v = v_q;
			end
			3'd5: begin
				pa_u = prior_u_q[0]; pa_v = prior_v_q[0];
				pb_u = prior_u_q[2]; pb_v = prior_v_q[2];
			end
			default: begin
				pa_u = prior_u_q[0]; pa_v = prior_v_q[0];
				pb_u = prior_u_q[1]; pb_v = prior_v_q[1];
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cam_z[31] || cam_z == '0)
						state_d = last ? ST_DIST : ST_OUT;
					else
						state_d = ST_XGO;
				end
			end
			ST_XGO:   state_d = ST_XWAIT;
			ST_XWAIT: if (div_done) state_d = ST_YGO;
			ST_YGO:   state_d = ST_YWAIT;
			ST_YWAIT: if (div_done) state_d = ST_POLY;
			ST_POLY:  if (step_q == 4'd13) state_d = ST_CGO;
			ST_CGO:   state_d = ST_CWAIT;
			ST_CWAIT: if (div_done) state_d = ST_TAN;
			ST_TAN:   if (step_q == 4'd8) state_d = last ? ST_DIST : ST_OUT;
			ST_DIST:  if (step_q == 4'd13) state_d = ST_OUT;
			ST_OUT:   if (out_ok) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = state_q != ST_IDLE;
		div_start = 1'b0;
		div_num   = cx_q;
		div_den   = cz_q;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_XGO: div_start = 1'b1;
			ST_YGO: begin
				div_start = 1'b1;
				div_num   = cy_q;
			end
			ST_CGO: begin
				div_start = 1'b1;
				div_num   = n_q;
				div_den   = d_q;
			end
			ST_POLY: begin
				case (step_q)
					4'd0:  begin mul_a = ext_opnd(x_q); mul_b = ext_opnd(x_q); end
					4'd1:  begin mul_a = ext_opnd(y_q); mul_b = ext_opnd(y_q); end
					4'd2:  begin mul_a = ext_opnd(x_q); mul_b = ext_opnd(y_q); end
					4'd4:  begin mul_a = ext_opnd(r2_q); mul_b = ext_opnd(r2_q); end
					4'd6:  begin mul_a = ext_opnd(r4_q); mul_b = ext_opnd(r2_q); end
					4'd7:  begin
						mul_a = ext_opnd(rad_num_q[63:32]); mul_b = ext_opnd(r2_q);
					end
					4'd8:  begin
						mul_a = ext_opnd(rad_num_q[31:0]); mul_b = ext_opnd(r4_q);
					end
					4'd9:  begin
						mul_a = ext_opnd(rad_mix_q[63:32]); mul_b = ext_opnd(r6_q);
					end
					4'd10: begin
						mul_a = ext_opnd(rad_mix_q[31:0]); mul_b = ext_opnd(r2_q);
					end
					4'd11: begin
						mul_a = ext_opnd(rad_den_q[63:32]); mul_b = ext_opnd(r4_q);
					end
					4'd12: begin
						mul_a = ext_opnd(rad_den_q[31:0]); mul_b = ext_opnd(r6_q);
					end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_TAN: begin
				case (step_q)
					4'd0: begin mul_a = ext_opnd(x_q); mul_b = ext_opnd(c_q); end
					4'd1: begin mul_a = ext_opnd(tang_q[63:32]); mul_b = ext_opnd(xy_q); end
					4'd2: begin mul_a = ext_opnd(tang_q[31:0]); mul_b = ext_opnd(tx_q); end
					4'd3: begin mul_a = ext_opnd(y_q); mul_b = ext_opnd(c_q); end
					4'd4: begin mul_a = ext_opnd(tang_q[63:32]); mul_b = ext_opnd(ty_q); end
					4'd5: begin mul_a = ext_opnd(tang_q[31:0]); mul_b = ext_opnd(xy_q); end
					4'd6: begin mul_a = {2'b00, focal_q[63:32]}; mul_b = ext_opnd(xd_q); end
					4'd7: begin mul_a = {2'b00, focal_q[31:0]}; mul_b = ext_opnd(yd_q); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_DIST: begin
				if (step_q == 4'd0) begin
					mul_a = {2'b00, min_dist_q};
					mul_b = {2'b00, min_dist_q};
				end else if (step_q[0]) begin
					mul_a = opnd_t'(du);
					mul_b = opnd_t'(du);
				end else begin
					mul_a = opnd_t'(dv);
					mul_b = opnd_t'(dv);
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid   <= 1'b0;
			count_q     <= '0;
			gai_q       <= 1'b1;
			focal_q     <= '0;
			principal_q <= '0;
			rad_num_q   <= '0;
			rad_mix_q   <= '0;
			rad_den_q   <= '0;
			tang_q      <= '0;
			image_q     <= '0;
			min_dist_q  <= MIN_DIST_RST;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				step_q <= '0;
			else if (state_q == ST_POLY || state_q == ST_TAN || state_q == ST_DIST)
				step_q <= step_q + 4'd1;

			if (cfg_write) begin
				unique case (cfg_index)
					REG_FOCAL:     focal_q     <= cfg_data;
					REG_PRINCIPAL: principal_q <= cfg_data;
					REG_RAD_NUM:   rad_num_q   <= cfg_data;
					REG_RAD_MIX:   rad_mix_q   <= cfg_data;
					REG_RAD_DEN:   rad_den_q   <= cfg_data;
					REG_TANG:      tang_q      <= cfg_data;
					REG_IMAGE:     image_q     <= cfg_data[31:0];
					REG_MIN_DIST:  min_dist_q  <= cfg_data[31:0];
					default:       ;
				endcase
			end

			if (state_q == ST_OUT && out_ok) begin
				out_valid <= 1'b1;
				if (last) begin
					count_q <= '0;
					gai_q   <= 1'b1;
				end else begin
					count_q <= count_q + 2'd1;
					gai_q   <= gai_q & in_image;
				end
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q     <= cam_x;
			cy_q     <= cam_y;
			cz_q     <= cam_z;
			behind_q <= cam_z[31] || cam_z == '0;
			u_q      <= '0;
			v_q      <= '0;
			far_q    <= 1'b1;
		end
		if (state_q == ST_XWAIT && div_done) x_q <= div_quo;
		if (state_q == ST_YWAIT && div_done) y_q <= div_quo;
		if (state_q == ST_CWAIT && div_done) c_q <= div_quo;

		if (state_q == ST_POLY) begin
			case (step_q)
				4'd1:  x2_q <= mq;
				4'd2:  y2_q <= mq;
				4'd3: begin
					xy_q <= mq;
					r2_q <= r2s;
					tx_q <= sat_word(ext_acc(r2s) + (ext_acc(x2_q) <<< 1));
					ty_q <= sat_word(ext_acc(r2s) + (ext_acc(y2_q) <<< 1));
				end
				4'd5:  r4_q <= mq;
				4'd7:  r6_q <= mq;
				4'd8:  acc_q <= ext_acc(one) + ext_acc(mq);
				4'd9:  acc_q <= acc_q + ext_acc(mq);
				4'd10: n_q <= sat_word(acc_q + ext_acc(mq));
				4'd11: acc_q <= ext_acc(one) + ext_acc(mq);
				4'd12: acc_q <= acc_q + ext_acc(mq);
				4'd13: d_q <= sat_word(acc_q + ext_acc(mq));
				default: ;
			endcase
		end

		if (state_q == ST_TAN) begin
			case (step_q)
				4'd1: acc_q <= ext_acc(mq);
				4'd2: acc_q <= acc_q + (ext_acc(mq) <<< 1);
				4'd3: xd_q <= sat_word(acc_q + ext_acc(mq));
				4'd4: acc_q <= ext_acc(mq);
				4'd5: acc_q <= acc_q + ext_acc(mq);
				4'd6: yd_q <= sat_word(acc_q + (ext_acc(mq) <<< 1));
				4'd7: u_q <= sat_word(ext_acc(mq) + acc_t'({1'b0, principal_q[63:32]}));
				4'd8: v_q <= sat_word(ext_acc(mq) + acc_t'({1'b0, principal_q[31:0]}));
				default: ;
			endcase
		end

		if (state_q == ST_DIST) begin
			if (step_q == 4'd1)
				mm_q <= prod;
			else if (!step_q[0] && step_q != 4'd0)
				a_q <= prod;
			if (step_q[0] && step_q != 4'd1 && !far_now)
				far_q <= 1'b0;
		end

		if (state_q == ST_OUT && out_ok) begin
			pixel_u       <= u_q;
			pixel_v       <= v_q;
			inside_image  <= in_image;
			behind_camera <= behind_q;
			corner_number <= count_q;
			last_corner   <= last;
			target_valid  <= last && gai_q && in_image && far_q;
			if (!last) begin
				prior_u_q[count_q] <= u_q;
				prior_v_q[count_q] <= v_q;
			end
		end
	end
endmodule

/* test/camera_point_projection_distortion_tb.sv */
// self-checking testbench for the pinhole projection block with lens distortion
module camera_point_projection_distortion_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cppd_pkg::*;

	typedef struct packed {
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic               in_img;
		logic               behind;
		logic [1:0]         num;
		logic               last;
		logic               tvalid;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = REG_FOCAL;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] cam_x = '0, cam_y = '0, cam_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] pixel_u, pixel_v;
	logic inside_image, behind_camera, last_corner, target_valid;
	logic [1:0] corner_number;

	camera_point_projection_distortion dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	pixel_t pixel_q[$];
	int mismatches = 0;
	int tx_max = 10, rx_max = 10, rx_hold = 0;

	logic [63:0] regs[8];
	longint prior_u[3], prior_v[3];
	int corner_cnt;
	bit all_inside;

	function automatic longint sat_to(longint v, int bits);
		longint top = longint'(1) << (bits - 1);
		if (v >= top) return top - 1;
		if (v < -top) return -top;
		return v;
	endfunction

	function automatic longint sat_of(bit neg, int bits);
		longint top = longint'(1) << (bits - 1);
		return neg ? -top : top - 1;
	endfunction

	function automatic longint mul_q(longint a, longint b, int bits);
		bit neg = (a < 0) != (b < 0);
		logic [127:0] p;
		p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		p = p >> FRAC;
		if (p >= (128'd1 << (bits - 1))) return sat_of(neg, bits);
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint div_q(longint n, longint d, int bits);
		bit neg = (n < 0) != (d < 0);
		logic [127:0] q;
		if (d == 0) return n == 0 ? 0 : sat_of(n < 0, bits);
		q = (128'(n < 0 ? -n : n) << FRAC) / 128'(d < 0 ? -d : d);
		if (q >= (128'd1 << (bits - 1))) return sat_of(neg, bits);
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic bit far_apart(longint u0, longint v0, longint u1, longint v1);
		logic [64:0] du, dv, s, m;
		du = 65'(u0 > u1 ? u0 - u1 : u1 - u0);
		dv = 65'(v0 > v1 ? v0 - v1 : v1 - v0);
		s = du * du + dv * dv;
		m = 65'(regs[REG_MIN_DIST][31:0]);
		if (s[64]) return 1'b1;
		return s >= m * m;
	endfunction

	function automatic longint hi32(logic [63:0] r);
		return longint'($signed(r[63:32]));
	endfunction

	function automatic longint lo32(logic [63:0] r);
		return longint'($signed(r[31:0]));
	endfunction

	function automatic pixel_t project_corner(logic [31:0] cx_in, logic [31:0] cy_in,
			logic [31:0] cz_in);
		pixel_t r;
		longint xq, yq, zq, x, y, x2, y2, xy, r2, r4, r6, n, d, c, xd, yd, one;
		longint u = 0, v = 0;
		bit in_img = 0;
		int num = corner_cnt;
		xq = longint'($signed(cx_in));
		yq = longint'($signed(cy_in));
		zq = longint'($signed(cz_in));
		one = longint'(1) << FRAC;
		if (zq > 0) begin
			x = div_q(xq, zq, 32);
			y = div_q(yq, zq, 32);
			x2 = mul_q(x, x, 32);
			y2 = mul_q(y, y, 32);
			xy = mul_q(x, y, 32);
			r2 = sat_to(x2 + y2, 32);
			r4 = mul_q(r2, r2, 32);
			r6 = mul_q(r4, r2, 32);
			n = sat_to(one + mul_q(hi32(regs[REG_RAD_NUM]), r2, 32)
				+ mul_q(lo32(regs[REG_RAD_NUM]), r4, 32)
				+ mul_q(hi32(regs[REG_RAD_MIX]), r6, 32), 32);
			d = sat_to(one + mul_q(lo32(regs[REG_RAD_MIX]), r2, 32)
				+ mul_q(hi32(regs[REG_RAD_DEN]), r4, 32)
				+ mul_q(lo32(regs[REG_RAD_DEN]), r6, 32), 32);
			c = div_q(n, d, 32);
			xd = sat_to(mul_q(x, c, 32) + 2 * mul_q(hi32(regs[REG_TANG]), xy, 32)
				+ mul_q(lo32(regs[REG_TANG]), sat_to(r2 + 2 * x2, 32), 32), 32);
			yd = sat_to(mul_q(y, c, 32)
				+ mul_q(hi32(regs[REG_TANG]), sat_to(r2 + 2 * y2, 32), 32)
				+ 2 * mul_q(lo32(regs[REG_TANG]), xy, 32), 32);
			u = sat_to(mul_q(longint'(regs[REG_FOCAL][63:32]), xd, 32)
				+ longint'(regs[REG_PRINCIPAL][63:32]), 32);
			v = sat_to(mul_q(longint'(regs[REG_FOCAL][31:0]), yd, 32)
				+ longint'(regs[REG_PRINCIPAL][31:0]), 32);
			in_img = u >= 0 && u < (longint'(regs[REG_IMAGE][31:16]) << 16)
				&& v >= 0 && v < (longint'(regs[REG_IMAGE][15:0]) << 16);
		end
		if (!in_img) all_inside = 0;
		r.tvalid = 0;
		if (num == 3) begin
			r.tvalid = all_inside
				&& far_apart(prior_u[0], prior_v[0], prior_u[1], prior_v[1])
				&& far_apart(prior_u[1], prior_v[1], prior_u[2], prior_v[2])
				&& far_apart(prior_u[2], prior_v[2], u, v)
				&& far_apart(u, v, prior_u[0], prior_v[0])
				&& far_apart(prior_u[1], prior_v[1], u, v)
				&& far_apart(prior_u[0], prior_v[0], prior_u[2], prior_v[2]);
			all_inside = 1;
			corner_cnt = 0;
		end else begin
			prior_u[num] = u;
			prior_v[num] = v;
			corner_cnt = num + 1;
		end
		r.u = u[31:0];
		r.v = v[31:0];
		r.in_img = in_img;
		r.behind = zq <= 0;
		r.num = num[1:0];
		r.last = num == 3;
		return r;
	endfunction

	task automatic send_corner(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		cam_x <= x;
		cam_y <= y;
		cam_z <= z;
		do @(posedge clk); while (in_stall);
		pixel_q.insert(pixel_q.size(), project_corner(x, y, z));
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		regs[idx] = val;
		if (idx >= REG_IMAGE) regs[idx] = {32'd0, val[31:0]};
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic camera_setup(logic [63:0] rn, logic [63:0] rm, logic [63:0] rd,
			logic [63:0] tg, logic [31:0] mind);
		write_reg(REG_FOCAL, {32'd500 << 16, 32'd480 << 16});
		write_reg(REG_PRINCIPAL, {32'd320 << 16, 32'd240 << 16});
		write_reg(REG_RAD_NUM, rn);
		write_reg(REG_RAD_MIX, rm);
		write_reg(REG_RAD_DEN, rd);
		write_reg(REG_TANG, tg);
		write_reg(REG_IMAGE, {32'd0, 16'd640, 16'd480});
		write_reg(REG_MIN_DIST, {32'd0, mind});
	endtask

	function automatic logic [31:0] small_coeff(int span);
		return 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic logic [63:0] coeff_pair(int span);
		return {small_coeff(span), small_coeff(span)};
	endfunction

	// corner in front of the camera, mostly within the field of view
	task automatic send_visible;
		longint z, xn, yn;
		z = $urandom_range(32'h1_0000, 32'h8_0000);
		xn = longint'($urandom_range(0, 36000)) - 18000;
		yn = longint'($urandom_range(0, 34000)) - 17000;
		send_corner(32'((xn * z) >>> 16), 32'((yn * z) >>> 16), 32'(z));
	endtask

	task automatic send_mixed(int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: send_corner($urandom, $urandom, $urandom);
				1: send_corner($urandom, $urandom, 32'($urandom_range(0, 3)));
				default: send_visible();
			endcase
		end
	endtask

	task automatic test_directed;
		// reset settings: zero focal length and empty image
		send_corner(32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
		send_corner(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		send_corner(32'h0, 32'h0, 32'h0);
		send_corner(32'h0, 32'h0, 32'h8000_0000);
		drain();
		camera_setup(coeff_pair(1 << 22), coeff_pair(1 << 22), coeff_pair(1 << 22),
			coeff_pair(1 << 18), 32'd10 << 16);
		// well spaced square, then one too tight, then one with a corner behind
		send_corner(-32'sh4000, -32'sh4000, 32'h2_0000);
		send_corner(32'h4000, -32'sh4000, 32'h2_0000);
		send_corner(32'h4000, 32'h4000, 32'h2_0000);
		send_corner(-32'sh4000, 32'h4000, 32'h2_0000);
		send_corner(32'h10, 32'h10, 32'h2_0000);
		send_corner(32'h11, 32'h10, 32'h2_0000);
		send_corner(32'h10, 32'h11, 32'h2_0000);
		send_corner(32'h11, 32'h11, 32'h2_0000);
		send_corner(32'h0, 32'h0, 32'h1_0000);
		send_corner(32'h1000, 32'h0, 32'hFFFF_0000);
		send_corner(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_corner(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
		send_corner(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
		send_corner(32'h0, 32'hFFFF_FFFF, 32'h0000_0001);
		send_corner(32'h0, 32'h0, 32'h8000_0001);
		send_corner(32'h1234_5678, 32'hEDCB_A987, 32'h0001_0000);
		drain();
	endtask

	task automatic test_zero_denominator;
		// denominator 1 - r2 vanishes at x = 1, y = 0
		write_reg(REG_RAD_NUM, 64'd0);
		write_reg(REG_RAD_MIX, {32'd0, -32'sd16777216});
		write_reg(REG_RAD_DEN, 64'd0);
		write_reg(REG_TANG, 64'd0);
		repeat (4) send_corner(32'h2_0000, 32'h0, 32'h2_0000);
		drain();
		// numerator vanishes too
		write_reg(REG_RAD_NUM, {-32'sd16777216, 32'd0});
		repeat (4) send_corner(-32'sh3_0000, 32'h0, 32'h3_0000);
		drain();
	endtask

	task automatic test_random;
		for (int ph = 0; ph < 5; ph++) begin
			tx_max = (ph == 2) ? 0 : 10;
			rx_max = (ph == 2) ? 0 : 10;
			camera_setup(coeff_pair(1 << 22), coeff_pair(1 << 22), coeff_pair(1 << 22),
				coeff_pair(1 << 19), ph == 3 ? 32'd300 << 16 : 32'($urandom_range(0, 40)) << 16);
			send_mixed(66);
			drain();
		end
		tx_max = 10;
		rx_max = 10;
		// extremes of every register
		for (int r = 0; r < 8; r++) write_reg(3'(r), '1);
		send_mixed(24);
		drain();
		for (int r = 0; r < 8; r++) write_reg(3'(r), '0);
		send_mixed(12);
		drain();
		for (int r = 0; r < 8; r++) write_reg(3'(r), {$urandom, $urandom});
		send_mixed(24);
		drain();
	endtask

	task automatic test_output_hold;
		camera_setup(coeff_pair(1 << 21), coeff_pair(1 << 21), coeff_pair(1 << 21),
			coeff_pair(1 << 18), 32'd10 << 16);
		tx_max = 0;
		rx_hold = 400;
		send_mixed(12);
		tx_max = 10;
		drain();
	endtask

	task automatic test_sender_pause;
		repeat (4) begin
			send_mixed(4);
			drain();
		end
	endtask

	// receive side stall pattern
	initial begin
		int n;
		@(negedge clk);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else
				n = $urandom_range(0, rx_max);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {pixel_u, pixel_v, inside_image, behind_camera, corner_number,
				last_corner, target_valid};
			if (pixel_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result u=%h v=%h", pixel_u, pixel_v);
			end else begin
				want = pixel_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp u=%h v=%h in=%b bh=%b n=%0d l=%b tv=%b, got u=%h v=%h in=%b bh=%b n=%0d l=%b tv=%b",
							want.u, want.v, want.in_img, want.behind, want.num, want.last,
							want.tvalid, got.u, got.v, got.in_img, got.behind, got.num,
							got.last, got.tvalid);
				end
			end
		end
	end

	initial begin
		regs = '{default: '0};
		regs[REG_MIN_DIST] = 64'(MIN_DIST_RST);
		corner_cnt = 0;
		all_inside = 1;
		prior_u = '{default: 0};
		prior_v = '{default: 0};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		test_zero_denominator();
		test_random();
		test_output_hold();
		test_sender_pause();
		drain();
		repeat (150) @(posedge clk);
		if (mismatches == 0 && pixel_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
